/* src/psrm_pkg.sv */
// ----------------------------------------------------------------------------
// psrm_pkg
// Shared types, constants and helpers of the per-symbol running median block.
// ----------------------------------------------------------------------------
`default_nettype none

package psrm_pkg;

  localparam int unsigned SYMBOLS_DEF     = 64;
  localparam int unsigned HEAP_DEPTH_DEF  = 128;
  localparam int unsigned PRICE_WIDTH_DEF = 32;

  localparam int unsigned SLOT_IN_W = 6;
  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned TSUM_W    = 34;
  localparam int unsigned TOTAL_W   = 64;
  localparam int unsigned SCORE_W   = 32;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_USE_MEDIAN = '0;

  typedef struct packed {
    logic [SLOT_IN_W-1:0]      symbol_slot;
    logic [31:0]               trade_volume;
    logic [31:0]               trade_count;
    logic signed [PRICE_W-1:0] high_price;
    logic signed [PRICE_W-1:0] low_price;
    logic signed [PRICE_W-1:0] close_price;
  } in_t;

  typedef struct packed {
    logic [SLOT_IN_W-1:0]      out_symbol;
    logic [TOTAL_W-1:0]        total_volume;
    logic [TOTAL_W-1:0]        total_trades;
    logic signed [SCORE_W-1:0] factor_score;
    logic signed [PRICE_W-1:0] running_median;
    logic                      heap_full;
  } out_t;

  typedef struct packed {
    logic [SLOT_IN_W-1:0]      symbol_slot;
    logic                      in_range;
    logic [31:0]               trade_volume;
    logic [31:0]               trade_count;
    logic signed [PRICE_W-1:0] close;
    logic signed [TSUM_W-1:0]  tsum;
  } qent_t;

  function automatic logic signed [PRICE_W-1:0] sext_price(logic [PRICE_W-1:0] v,
                                                          int unsigned pw);
    int unsigned sh;
    sh = PRICE_W - pw;
    return $signed(v << sh) >>> sh;
  endfunction

  function automatic logic ranks_above(logic signed [PRICE_W-1:0] a,
                                       logic signed [PRICE_W-1:0] b,
                                       logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

/* src/psrm_ram.sv */
// ----------------------------------------------------------------------------
// psrm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/psrm_front.sv */
// ----------------------------------------------------------------------------
// psrm_front
// Takes bars, checks the slot, forms the price sum, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module psrm_front #(
  parameter int unsigned SYMBOLS     = psrm_pkg::SYMBOLS_DEF,
  parameter int unsigned PRICE_WIDTH = psrm_pkg::PRICE_WIDTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire psrm_pkg::in_t   item_i,
  input  wire logic            clearing_i,
  output logic                 busy_o,
  output logic                 q_valid_o,
  output psrm_pkg::qent_t      q_item_o,
  input  wire logic            pop_i
);
  import psrm_pkg::*;

  localparam int unsigned QD = 2;

  logic signed [PRICE_W-1:0] hp, lp, cp;
  qent_t                     ent;
  qent_t                     ent_q [QD];
  logic                      wptr_q, rptr_q;
  logic [1:0]                cnt_q;

  always_comb begin
    hp = sext_price(item_i.high_price, PRICE_WIDTH);
    lp = sext_price(item_i.low_price, PRICE_WIDTH);
    cp = sext_price(item_i.close_price, PRICE_WIDTH);
    ent.symbol_slot  = item_i.symbol_slot;
    ent.in_range     = 16'(item_i.symbol_slot) < 16'(SYMBOLS);
    ent.trade_volume = item_i.trade_volume;
    ent.trade_count  = item_i.trade_count;
    ent.close        = cp;
    ent.tsum         = TSUM_W'(hp) + TSUM_W'(lp) + TSUM_W'(cp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        ent_q[wptr_q] <= ent;
        wptr_q        <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign busy_o    = (cnt_q == 2'(QD)) || clearing_i;
  assign q_valid_o = cnt_q != '0;
  assign q_item_o  = ent_q[rptr_q];

endmodule

`default_nettype wire

/* src/psrm_back.sv */
// ----------------------------------------------------------------------------
// psrm_back
// Executes one bar: slot totals, two-heap median update, score, result.
// ----------------------------------------------------------------------------
`default_nettype none

module psrm_back #(
  parameter int unsigned SYMBOLS     = psrm_pkg::SYMBOLS_DEF,
  parameter int unsigned HEAP_DEPTH  = psrm_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned PRICE_WIDTH = psrm_pkg::PRICE_WIDTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire psrm_pkg::qent_t q_item_i,
  output logic                 pop_o,
  input  wire logic            use_median_i,
  output logic                 clearing_o,
  output logic                 done_o,
  output psrm_pkg::out_t       result_o
);
  import psrm_pkg::*;

  localparam int unsigned SLOT_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned HD_W    = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IDX_W   = HD_W + 1;
  localparam int unsigned HADDR_W = SLOT_W + HD_W;

  typedef struct packed {
    logic [TOTAL_W-1:0] vol;
    logic [TOTAL_W-1:0] trd;
    logic [SCORE_W-1:0] fac;
    logic [CNT_W-1:0]   lc;
    logic [CNT_W-1:0]   uc;
  } stat_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_PU_CHK, S_PU_CMP, S_SD_L, S_SD_R, S_SD_C2,
    S_TOPS, S_MED, S_FIN
  } state_e;

  state_e                    state_q, state_d;
  logic [SLOT_W-1:0]         clr_q, clr_d, sidx_q, sidx_d, sidx_in, rslot;
  qent_t                     item_q, item_d;
  stat_t                     st_q, st_d, st_rd;
  logic                      hsel_q, hsel_d, sec_q, sec_d, sec_hi_q, sec_hi_d;
  logic signed [PRICE_W-1:0] val_q, val_d, sec_val_q, sec_val_d, hl_q, hl_d;
  logic signed [PRICE_W-1:0] med_q, med_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      drop_q, drop_d, done_q, done_d;
  out_t                      res_q, res_d;

  logic [SLOT_W+SLOT_IN_W-1:0] in_slot_ext;
  logic                        stat_we;
  logic [SLOT_W-1:0]           stat_waddr;
  logic [$bits(stat_t)-1:0]    stat_rdata;
  logic                        h_we;
  logic [IDX_W-1:0]            h_widx, h_ridx;
  logic [PRICE_WIDTH-1:0]      h_wdata, lo_rdata, hi_rdata;
  logic signed [PRICE_W-1:0]   lo_v, hi_v, h_rd, sd_hc;
  logic                        is_max, sd_pick_r, sd_move, op_fin;
  logic [IDX_W-1:0]            l_idx, r_idx, im1, par, cnt_x, sd_c;
  logic                        full, gt;
  logic [CNT_W:0]              tot;
  logic signed [PRICE_W:0]     msum, madj;
  logic signed [TSUM_W-1:0]    refv;
  logic signed [TSUM_W+1:0]    tsum_x, ref3;
  logic                        typ_lt;

  assign in_slot_ext = (SLOT_W + SLOT_IN_W)'(q_item_i.symbol_slot);
  assign sidx_in     = in_slot_ext[SLOT_W-1:0];
  assign rslot       = (state_q == S_IDLE) ? sidx_in : sidx_q;
  assign st_rd       = stat_t'(stat_rdata);

  assign lo_v   = sext_price(PRICE_W'(lo_rdata), PRICE_WIDTH);
  assign hi_v   = sext_price(PRICE_W'(hi_rdata), PRICE_WIDTH);
  assign is_max = ~hsel_q;
  assign h_rd   = hsel_q ? hi_v : lo_v;

  assign l_idx = {idx_q[HD_W-1:0], 1'b1};
  assign r_idx = l_idx + IDX_W'(1);
  assign im1   = idx_q - IDX_W'(1);
  assign par   = im1 >> 1;
  assign cnt_x = IDX_W'(cnt_q);

  assign sd_pick_r = (state_q == S_SD_C2) && ranks_above(h_rd, hl_q, is_max);
  assign sd_c      = sd_pick_r ? r_idx : l_idx;
  assign sd_hc     = (state_q == S_SD_C2 && !sd_pick_r) ? hl_q : h_rd;
  assign sd_move   = ranks_above(sd_hc, val_q, is_max);

  assign tot  = {1'b0, st_rd.lc} + {1'b0, st_rd.uc};
  assign full = tot >= (CNT_W + 1)'(2 * HEAP_DEPTH);
  assign gt   = st_rd.lc > st_rd.uc;

  assign msum = (PRICE_W + 1)'(lo_v) + (PRICE_W + 1)'(hi_v);
  assign madj = msum + (PRICE_W + 1)'(msum[PRICE_W]);

  assign refv = use_median_i ? TSUM_W'(med_q) : TSUM_W'(item_q.close);

  // trunc(t/3) < r: t < 3r for t >= 0, t <= 3r - 3 for t < 0
  assign tsum_x = (TSUM_W + 2)'(item_q.tsum);
  assign ref3   = ((TSUM_W + 2)'(refv) <<< 1) + (TSUM_W + 2)'(refv);
  assign typ_lt = item_q.tsum[TSUM_W-1] ? (tsum_x <= ref3 - (TSUM_W + 2)'(3))
                                        : (tsum_x < ref3);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    item_d    = item_q;
    sidx_d    = sidx_q;
    st_d      = st_q;
    hsel_d    = hsel_q;
    val_d     = val_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    hl_d      = hl_q;
    sec_d     = sec_q;
    sec_hi_d  = sec_hi_q;
    sec_val_d = sec_val_q;
    drop_d    = drop_q;
    med_d     = med_q;
    res_d     = res_q;
    done_d    = 1'b0;
    pop_o      = 1'b0;
    stat_we    = 1'b0;
    stat_waddr = sidx_q;
    h_we       = 1'b0;
    h_widx     = idx_q;
    h_wdata    = val_q[PRICE_WIDTH-1:0];
    h_ridx     = '0;
    op_fin     = 1'b0;

    case (state_q)
      S_CLEAR: begin
        stat_we    = 1'b1;
        stat_waddr = clr_q;
        st_d       = '0;
        clr_d      = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(SYMBOLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o     = 1'b1;
          item_d    = q_item_i;
          sidx_d    = sidx_in;
          drop_d    = 1'b0;
          sec_d     = 1'b0;
          if (q_item_i.in_range) begin
            state_d = S_DEC;
          end else begin
            res_d            = '0;
            res_d.out_symbol = q_item_i.symbol_slot;
            done_d           = 1'b1;
          end
        end
      end
      S_DEC: begin
        st_d = st_rd;
        if (full) begin
          drop_d  = 1'b1;
          state_d = S_TOPS;
        end else if (st_rd.lc == '0 || item_q.close <= lo_v) begin
          if (gt) begin
            hsel_d    = 1'b0;
            val_d     = item_q.close;
            idx_d     = '0;
            cnt_d     = st_rd.lc;
            sec_d     = 1'b1;
            sec_hi_d  = 1'b1;
            sec_val_d = lo_v;
            state_d   = S_SD_L;
          end else begin
            hsel_d   = 1'b0;
            val_d    = item_q.close;
            idx_d    = IDX_W'(st_rd.lc);
            st_d.lc  = st_rd.lc + CNT_W'(1);
            state_d  = S_PU_CHK;
          end
        end else if (!gt) begin
          if (st_rd.uc == '0 || item_q.close <= hi_v) begin
            hsel_d   = 1'b0;
            val_d    = item_q.close;
            idx_d    = IDX_W'(st_rd.lc);
            st_d.lc  = st_rd.lc + CNT_W'(1);
            state_d  = S_PU_CHK;
          end else begin
            hsel_d    = 1'b1;
            val_d     = item_q.close;
            idx_d     = '0;
            cnt_d     = st_rd.uc;
            sec_d     = 1'b1;
            sec_hi_d  = 1'b0;
            sec_val_d = hi_v;
            state_d   = S_SD_L;
          end
        end else begin
          hsel_d   = 1'b1;
          val_d    = item_q.close;
          idx_d    = IDX_W'(st_rd.uc);
          st_d.uc  = st_rd.uc + CNT_W'(1);
          state_d  = S_PU_CHK;
        end
      end
      S_PU_CHK: begin
        if (idx_q == '0) begin
          h_we   = 1'b1;
          op_fin = 1'b1;
        end else begin
          h_ridx  = par;
          state_d = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        h_we = 1'b1;
        if (ranks_above(val_q, h_rd, is_max)) begin
          h_wdata = h_rd[PRICE_WIDTH-1:0];
          idx_d   = par;
          state_d = S_PU_CHK;
        end else begin
          op_fin = 1'b1;
        end
      end
      S_SD_L: begin
        if (l_idx >= cnt_x) begin
          h_we   = 1'b1;
          op_fin = 1'b1;
        end else begin
          h_ridx  = l_idx;
          state_d = S_SD_R;
        end
      end
      S_SD_R, S_SD_C2: begin
        hl_d = h_rd;
        if (state_q == S_SD_R && r_idx < cnt_x) begin
          h_ridx  = r_idx;
          state_d = S_SD_C2;
        end else begin
          h_we = 1'b1;
          if (sd_move) begin
            h_wdata = sd_hc[PRICE_WIDTH-1:0];
            idx_d   = sd_c;
            state_d = S_SD_L;
          end else begin
            op_fin = 1'b1;
          end
        end
      end
      S_TOPS: begin
        state_d = S_MED;
      end
      S_MED: begin
        if (st_q.lc == '0) begin
          med_d = '0;
        end else if (st_q.lc == st_q.uc) begin
          med_d = madj[PRICE_W:1];
        end else begin
          med_d = lo_v;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        st_d.vol = st_q.vol + TOTAL_W'(item_q.trade_volume);
        st_d.trd = st_q.trd + TOTAL_W'(item_q.trade_count);
        st_d.fac = st_q.fac + (typ_lt ? SCORE_W'(1) : '1);
        stat_we  = 1'b1;
        res_d.out_symbol     = item_q.symbol_slot;
        res_d.total_volume   = st_d.vol;
        res_d.total_trades   = st_d.trd;
        res_d.factor_score   = st_d.fac;
        res_d.running_median = med_q;
        res_d.heap_full      = drop_q;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (op_fin) begin
      if (sec_q) begin
        sec_d  = 1'b0;
        hsel_d = sec_hi_q;
        val_d  = sec_val_q;
        if (sec_hi_q) begin
          idx_d   = IDX_W'(st_q.uc);
          st_d.uc = st_q.uc + CNT_W'(1);
        end else begin
          idx_d   = IDX_W'(st_q.lc);
          st_d.lc = st_q.lc + CNT_W'(1);
        end
        state_d = S_PU_CHK;
      end else begin
        state_d = S_TOPS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      sec_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      sec_q     <= sec_d;
      done_q    <= done_d;
      item_q    <= item_d;
      sidx_q    <= sidx_d;
      st_q      <= st_d;
      hsel_q    <= hsel_d;
      val_q     <= val_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      hl_q      <= hl_d;
      sec_hi_q  <= sec_hi_d;
      sec_val_q <= sec_val_d;
      drop_q    <= drop_d;
      med_q     <= med_d;
      res_q     <= res_d;
    end
  end

  psrm_ram #(.WIDTH($bits(stat_t)), .DEPTH(SYMBOLS)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (stat_waddr),
    .wdata_i (st_d),
    .raddr_i (sidx_in),
    .rdata_o (stat_rdata)
  );

  psrm_ram #(.WIDTH(PRICE_WIDTH), .DEPTH(1 << HADDR_W)) u_lo_ram (
    .clk_i   (clk_i),
    .we_i    (h_we & ~hsel_q),
    .waddr_i ({sidx_q, h_widx[HD_W-1:0]}),
    .wdata_i (h_wdata),
    .raddr_i ({rslot, h_ridx[HD_W-1:0]}),
    .rdata_o (lo_rdata)
  );

  psrm_ram #(.WIDTH(PRICE_WIDTH), .DEPTH(1 << HADDR_W)) u_hi_ram (
    .clk_i   (clk_i),
    .we_i    (h_we & hsel_q),
    .waddr_i ({sidx_q, h_widx[HD_W-1:0]}),
    .wdata_i (h_wdata),
    .raddr_i ({rslot, h_ridx[HD_W-1:0]}),
    .rdata_o (hi_rdata)
  );

  assign clearing_o = state_q == S_CLEAR;
  assign done_o     = done_q;
  assign result_o   = res_q;

endmodule

`default_nettype wire

/* src/per_symbol_running_median_factor_top.sv */
// ----------------------------------------------------------------------------
// per_symbol_running_median_factor_top
// Per-slot volume/trade totals, running median of closes and factor score.
//
// A bar transaction is taken when start is high and busy is low. Bars wait
// in a two-entry queue in front of the execution engine. Each bar gives one
// result, shown on result_o for exactly one cycle with done_o high; the
// receiver cannot stall it. A bar for a slot at or above SYMBOLS gives an
// all-zero result (slot kept) the cycle after it leaves the queue.
// A valid bar's time in the engine is set by the heap sifts: they are
// read-modify-writes through one read port per heap memory, and the
// worst case is a top replacement followed by a push into the other heap.
// The sum of the three prices is compared against three times the
// reference, so no divider adds time. After reset busy stays high while
// the slot totals and heap counts are cleared; configuration writes are
// taken during that time.
// use_median sits at byte address 0 of the APB port and resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module per_symbol_running_median_factor_top #(
  parameter int unsigned SYMBOLS     = psrm_pkg::SYMBOLS_DEF,
  parameter int unsigned HEAP_DEPTH  = psrm_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned PRICE_WIDTH = psrm_pkg::PRICE_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire psrm_pkg::in_t                in_i,
  output logic                              done_o,
  output psrm_pkg::out_t                    result_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [psrm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [psrm_pkg::APB_DW-1:0]  pwdata,
  output logic      [psrm_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);
  import psrm_pkg::*;

  logic  use_median_q, cfg_we, reg_hit;
  logic  clearing, q_valid, pop;
  qent_t q_item;

  assign pready  = 1'b1;
  assign reg_hit = paddr[APB_AW-1:2] == REG_USE_MEDIAN;
  assign cfg_we  = psel & penable & pwrite & reg_hit;
  assign prdata  = reg_hit ? APB_DW'(use_median_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_median_q <= 1'b1;
    end else if (cfg_we) begin
      use_median_q <= pwdata[0];
    end
  end

  psrm_front #(.SYMBOLS(SYMBOLS), .PRICE_WIDTH(PRICE_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start & ~busy),
    .item_i     (in_i),
    .clearing_i (clearing),
    .busy_o     (busy),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .pop_i      (pop)
  );

  psrm_back #(
    .SYMBOLS     (SYMBOLS),
    .HEAP_DEPTH  (HEAP_DEPTH),
    .PRICE_WIDTH (PRICE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .pop_o        (pop),
    .use_median_i (use_median_q),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

/* src/psrm_checker.sv */
// ----------------------------------------------------------------------------
// psrm_checker
// Port-level checks of the running median block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psrm_checker #(
  parameter int unsigned SYMBOLS = psrm_pkg::SYMBOLS_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         busy,
  input wire logic                         done_o,
  input wire psrm_pkg::out_t               result_o,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [psrm_pkg::APB_AW-1:0]  paddr,
  input wire logic [psrm_pkg::APB_DW-1:0]  pwdata,
  input wire logic [psrm_pkg::APB_DW-1:0]  prdata,
  input wire logic                         pready
);
  import psrm_pkg::*;

  logic out_of_range, reg_hit;

  assign out_of_range = 16'(result_o.out_symbol) >= 16'(SYMBOLS);
  assign reg_hit      = paddr[APB_AW-1:2] == REG_USE_MEDIAN;

  a_busy_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> busy)
    else $error("not busy while slot state is cleared");

  a_bad_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range |-> result_o.total_volume == '0 &&
      result_o.total_trades == '0 && result_o.factor_score == '0 &&
      result_o.running_median == '0 && !result_o.heap_full)
    else $error("result for unknown slot is not zero");

  a_full_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.heap_full |-> !out_of_range)
    else $error("heap full flagged for unknown slot");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && reg_hit) ##1
      (psel && !pwrite && reg_hit) |-> prdata[0] == $past(pwdata[0]))
    else $error("use_median readback differs from last write");

endmodule

bind per_symbol_running_median_factor_top psrm_checker #(.SYMBOLS(SYMBOLS)) u_psrm_checker (.*);

`default_nettype wire

/* tb/tb_per_symbol_running_median_factor_top.sv */
// ----------------------------------------------------------------------------
// tb_per_symbol_running_median_factor_top
// Self-checking bench for the per-symbol running median factor block.
//
// Bars are sent through the start/busy handshake. Each accepted transaction
// is run through an in-bench model of the slot totals, the two-heap median
// and the factor score. A monitor then compares every done_o result, field
// by field, against the oldest pending prediction. The use_median register
// is written over APB only while the block is idle. The run covers directed
// extremes, mode changes, a slot filled past heap capacity and random bars
// with bursty gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_per_symbol_running_median_factor_top;
  import psrm_pkg::*;

  localparam int NSLOT = 64;
  localparam int DEPTH = 128;
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 600000;
  localparam logic [APB_AW-1:0] ADDR_USE_MEDIAN = {REG_USE_MEDIAN, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNUSED = 3'd4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_i = '0;
  logic done_o;
  out_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // predictor state: heap 0 is the lower max-heap, heap 1 the upper min-heap
  logic [63:0] vol_tot [NSLOT];
  logic [63:0] trd_tot [NSLOT];
  logic [31:0] score_tot [NSLOT];
  int heap [2][NSLOT][DEPTH];
  int hcnt [2][NSLOT];
  bit cfg_median;

  out_t expected_q [$];
  longint cycles = 0;
  int errors = 0;
  int bars_sent = 0;
  int results_seen = 0;
  int drops_seen = 0;
  bit bursty = 1'b1;
  bit quiet = 1'b0;

  per_symbol_running_median_factor_top dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("** per_symbol_running_median_factor_top: FAILED **");
      $finish;
    end
  end

  function automatic bit ranks(int a, int b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  function automatic void hpush(int h, int s, int v);
    int i;
    int p;
    i = hcnt[h][s];
    hcnt[h][s]++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks(v, heap[h][s][p], h == 0)) break;
      heap[h][s][i] = heap[h][s][p];
      i = p;
    end
    heap[h][s][i] = v;
  endfunction

  function automatic int hreplace(int h, int s, int v);
    int old;
    int i;
    int l;
    int c;
    old = heap[h][s][0];
    i = 0;
    forever begin
      l = 2 * i + 1;
      if (l >= hcnt[h][s]) break;
      c = l;
      if (l + 1 < hcnt[h][s] && ranks(heap[h][s][l+1], heap[h][s][l], h == 0)) c = l + 1;
      if (!ranks(heap[h][s][c], v, h == 0)) break;
      heap[h][s][i] = heap[h][s][c];
      i = c;
    end
    heap[h][s][i] = v;
    return old;
  endfunction

  function automatic bit median_insert(int s, int x);
    int lc;
    int uc;
    lc = hcnt[0][s];
    uc = hcnt[1][s];
    if (lc + uc >= 2 * DEPTH) return 1'b1;
    if (lc == 0 || x <= heap[0][s][0]) begin
      if (lc > uc) hpush(1, s, hreplace(0, s, x));
      else hpush(0, s, x);
    end else if (uc >= lc) begin
      if (uc == 0 || x <= heap[1][s][0]) hpush(0, s, x);
      else hpush(0, s, hreplace(1, s, x));
    end else begin
      hpush(1, s, x);
    end
    return 1'b0;
  endfunction

  function automatic out_t predict_bar(in_t b);
    out_t r;
    int s;
    longint typical;
    longint med;
    longint refp;
    bit dropped;
    s = b.symbol_slot;
    vol_tot[s] += 64'(b.trade_volume);
    trd_tot[s] += 64'(b.trade_count);
    typical = (longint'(b.high_price) + longint'(b.low_price) + longint'(b.close_price)) / 3;
    dropped = median_insert(s, b.close_price);
    if (hcnt[0][s] == 0) med = 0;
    else if (hcnt[0][s] == hcnt[1][s])
      med = (longint'(heap[0][s][0]) + longint'(heap[1][s][0])) / 2;
    else med = heap[0][s][0];
    refp = cfg_median ? med : longint'(b.close_price);
    score_tot[s] += (typical < refp) ? 32'd1 : 32'hFFFF_FFFF;
    r.out_symbol = b.symbol_slot;
    r.total_volume = vol_tot[s];
    r.total_trades = trd_tot[s];
    r.factor_score = score_tot[s];
    r.running_median = med[31:0];
    r.heap_full = dropped;
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (result_o.heap_full) drops_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, result_o);
      end else begin
        e = expected_q.pop_front();
        if (e.out_symbol !== result_o.out_symbol) begin
          errors++;
          $display("%0t: out_symbol exp %0d got %0d", $time, e.out_symbol, result_o.out_symbol);
        end
        if (e.total_volume !== result_o.total_volume) begin
          errors++;
          $display("%0t: total_volume exp %h got %h", $time, e.total_volume,
                   result_o.total_volume);
        end
        if (e.total_trades !== result_o.total_trades) begin
          errors++;
          $display("%0t: total_trades exp %h got %h", $time, e.total_trades,
                   result_o.total_trades);
        end
        if (e.factor_score !== result_o.factor_score) begin
          errors++;
          $display("%0t: factor_score exp %0d got %0d", $time, e.factor_score,
                   result_o.factor_score);
        end
        if (e.running_median !== result_o.running_median) begin
          errors++;
          $display("%0t: running_median exp %0d got %0d", $time, e.running_median,
                   result_o.running_median);
        end
        if (e.heap_full !== result_o.heap_full) begin
          errors++;
          $display("%0t: heap_full exp %b got %b", $time, e.heap_full, result_o.heap_full);
        end
      end
    end
  end

  task automatic send_bar(in_t b);
    if (!quiet && bursty && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_i <= b;
    start <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    expected_q.push_back(predict_bar(b));
    bars_sent++;
    if (bars_sent % 97 == 0) bursty = ~bursty;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_USE_MEDIAN) cfg_median = data[0];
  endtask

  function automatic in_t mk_bar(int s, logic [31:0] v, logic [31:0] c,
                                 int h, int l, int cl);
    in_t b;
    b.symbol_slot = SLOT_IN_W'(s);
    b.trade_volume = v;
    b.trade_count = c;
    b.high_price = h;
    b.low_price = l;
    b.close_price = cl;
    return b;
  endfunction

  function automatic in_t rand_bar(int slot_hi);
    int base;
    if ($urandom_range(0, 9) < 3)
      return mk_bar($urandom_range(0, 63), $urandom, $urandom, $urandom, $urandom, $urandom);
    base = $urandom_range(0, 1) ? 0 : int'($urandom);
    return mk_bar($urandom_range(0, slot_hi), $urandom_range(0, 5000), $urandom_range(0, 300),
                  base + $urandom_range(0, 60), base - $urandom_range(0, 60),
                  base + $urandom_range(0, 60) - 30);
  endfunction

  task automatic test_extremes();
    send_bar(mk_bar(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_bar(mk_bar(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_bar(mk_bar(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_bar(mk_bar(0, 1, 1, -1, -2, -2));
    send_bar(mk_bar(63, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_bar(mk_bar(63, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_bar(mk_bar(63, 7, 7, -4, -5, -5));
    // ties, lower-top insertions, upper-top swaps, negative truncation
    send_bar(mk_bar(1, 10, 1, 10, 10, 10));
    send_bar(mk_bar(1, 10, 1, 10, 10, 10));
    send_bar(mk_bar(1, 10, 1, 5, 5, 5));
    send_bar(mk_bar(1, 10, 1, 20, 20, 20));
    send_bar(mk_bar(1, 10, 1, 30, 30, 30));
    send_bar(mk_bar(1, 10, 1, 1, 1, 1));
    send_bar(mk_bar(2, 3, 3, -3, -3, -3));
    send_bar(mk_bar(2, 3, 3, -1, -2, -4));
    send_bar(mk_bar(2, 3, 3, 2, 2, 2));
    wait_idle();
  endtask

  task automatic test_mode_switch();
    apb_write(ADDR_USE_MEDIAN, 32'h0);
    for (int i = 0; i < 8; i++) send_bar(rand_bar(3));
    send_bar(mk_bar(3, 1, 1, 9, 9, 9));
    send_bar(mk_bar(3, 1, 1, 9, 8, 9));
    wait_idle();
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_bar(rand_bar(3));
    wait_idle();
    apb_write(ADDR_USE_MEDIAN, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_bar(rand_bar(3));
    wait_idle();
  endtask

  task automatic test_heap_full();
    for (int i = 0; i < 2 * DEPTH + 8; i++)
      send_bar(mk_bar(40, $urandom_range(0, 99), 1, 0, 0, $urandom_range(0, 400) - 200));
    wait_idle();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3 || i == 2 * n / 3) begin
        wait_idle();
        apb_write(ADDR_USE_MEDIAN, {31'h0, ~cfg_median});
      end
      if (i > n - n / 8) quiet = 1'b1;
      send_bar(rand_bar($urandom_range(0, 1) ? 7 : 63));
    end
  endtask

  initial begin
    for (int s = 0; s < NSLOT; s++) begin
      vol_tot[s] = '0;
      trd_tot[s] = '0;
      score_tot[s] = '0;
      hcnt[0][s] = 0;
      hcnt[1][s] = 0;
    end
    cfg_median = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_mode_switch();
    test_heap_full();
    test_random(1000);
    wait_idle();
    $display("%0d bars sent, %0d results checked, %0d dropped closes",
             bars_sent, results_seen, drops_seen);
    $display("covered extremes, both score modes, full heaps and random bars");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** per_symbol_running_median_factor_top: PASSED **");
    end else begin
      $display("** per_symbol_running_median_factor_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
src/psrm_pkg.sv
src/psrm_ram.sv
src/psrm_front.sv
src/psrm_back.sv
src/per_symbol_running_median_factor_top.sv
src/psrm_checker.sv
tb/tb_per_symbol_running_median_factor_top.sv
